// ----- rtl/mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// mbe_pkg: shared types and constants for the escape-time core
// Fixed-point widths, register indexes, the queued job record and the
// saturation helper used by the coordinate mapper and the iteration engine.
// ----------------------------------------------------------------------------
package mbe_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 28;

	localparam int ITER_W     = 16;
	localparam int ORIGIN_W   = 32;
	localparam int STEP_W     = 31;
	localparam int Z_W        = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RE_ORIGIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IM_ORIGIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RE_STEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IM_STEP   = 3'd4;

	localparam logic [ITER_W-1:0]     MAX_ITER_RST  = 16'd4096;
	localparam logic [ORIGIN_W-1:0]   RE_ORIGIN_RST = 32'hE000_0000;
	localparam logic [ORIGIN_W-1:0]   IM_ORIGIN_RST = 32'hECCC_CCCD;
	localparam logic [STEP_W-1:0]     RE_STEP_RST   = 31'd419430;
	localparam logic [STEP_W-1:0]     IM_STEP_RST   = 31'd596523;

	// pixel * step product and origin + product sum
	localparam int PROD_W = COORD_BITS + STEP_W;
	localparam int SUM_W  = PROD_W + 2;

	// shifted squares and cross term, with headroom for the z update sums
	localparam int MAG_W  = 2 * Z_W - FRAC_BITS + 2;
	localparam logic [MAG_W-1:0] MAG_FOUR = MAG_W'(4) << FRAC_BITS;

	localparam int SAT_W  = (MAG_W > SUM_W) ? MAG_W : SUM_W;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// input stage + queue + engine + output register
	localparam int OUTSTANDING_MAX = QUEUE_DEPTH + 3;
	localparam int PEND_W          = $clog2(OUTSTANDING_MAX + 1);

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic signed [Z_W-1:0] cr;
		logic signed [Z_W-1:0] ci;
	} mbe_job_t;

	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_MUL,
		ENG_CHK,
		ENG_OUT
	} mbe_eng_state_t;

	function automatic logic signed [Z_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
		logic signed [Z_W-1:0] r;
		if (v[SAT_W-1:Z_W-1] == '0 || v[SAT_W-1:Z_W-1] == '1) begin
			r = v[Z_W-1:0];
		end else if (v[SAT_W-1]) begin
			r = {1'b1, {(Z_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(Z_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

// ----- rtl/mbe_front.sv -----
// ----------------------------------------------------------------------------
// mbe_front: pixel intake and coordinate mapping
// Accepts a pixel, forms pixel * step per axis, then adds the origin with
// saturation and hands the finished job to the queue.
// ----------------------------------------------------------------------------
module mbe_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [mbe_pkg::COORD_BITS-1:0]       pixel_x,
	input  logic [mbe_pkg::COORD_BITS-1:0]       pixel_y,
	input  logic signed [mbe_pkg::ORIGIN_W-1:0]  re_origin,
	input  logic signed [mbe_pkg::ORIGIN_W-1:0]  im_origin,
	input  logic [mbe_pkg::STEP_W-1:0]           re_step,
	input  logic [mbe_pkg::STEP_W-1:0]           im_step,
	output logic                                 job_push,
	output mbe_pkg::mbe_job_t                    job,
	input  logic                                 job_ready
);
	import mbe_pkg::*;

	logic                  v_s1_q;
	logic [COORD_BITS-1:0] x_s1;
	logic [COORD_BITS-1:0] y_s1;
	logic [PROD_W-1:0]     prod_re_s1;
	logic [PROD_W-1:0]     prod_im_s1;
	logic signed [SUM_W-1:0] sum_re;
	logic signed [SUM_W-1:0] sum_im;

	assign job_push = v_s1_q && job_ready;
	assign in_ready = !v_s1_q || job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (in_ready) begin
			v_s1_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_s1       <= pixel_x;
			y_s1       <= pixel_y;
			prod_re_s1 <= PROD_W'(pixel_x) * PROD_W'(re_step);
			prod_im_s1 <= PROD_W'(pixel_y) * PROD_W'(im_step);
		end
	end

	assign sum_re = $signed({2'b00, prod_re_s1}) + SUM_W'(re_origin);
	assign sum_im = $signed({2'b00, prod_im_s1}) + SUM_W'(im_origin);

	always_comb begin
		job.x  = x_s1;
		job.y  = y_s1;
		job.cr = sat32(SAT_W'(sum_re));
		job.ci = sat32(SAT_W'(sum_im));
	end

endmodule

// ----- rtl/mbe_fifo.sv -----
// ----------------------------------------------------------------------------
// mbe_fifo: short job queue
// Decouples coordinate mapping from the iteration engine.
// ----------------------------------------------------------------------------
module mbe_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mbe_pkg::mbe_job_t wr_job,
	output logic              not_full,
	input  logic              pop,
	output mbe_pkg::mbe_job_t rd_job,
	output logic              not_empty
);
	import mbe_pkg::*;

	mbe_job_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign not_full  = count_q != QCNT_W'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign rd_job    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

// ----- rtl/mbe_iter.sv -----
// ----------------------------------------------------------------------------
// mbe_iter: escape-time iteration engine and result register
// Runs z = z*z + c, one update per pass through the multiply and check
// states, and holds the finished result until the consumer takes it.
// ----------------------------------------------------------------------------
module mbe_iter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [mbe_pkg::ITER_W-1:0]       max_iter,
	input  logic                             job_valid,
	input  mbe_pkg::mbe_job_t                job,
	output logic                             job_pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [mbe_pkg::COORD_BITS-1:0]   out_x,
	output logic [mbe_pkg::COORD_BITS-1:0]   out_y,
	output logic [mbe_pkg::ITER_W-1:0]       iterations,
	output logic                             escaped
);
	import mbe_pkg::*;

	mbe_eng_state_t state_q;
	mbe_eng_state_t state_d;

	logic [COORD_BITS-1:0]   x_q;
	logic [COORD_BITS-1:0]   y_q;
	logic signed [Z_W-1:0]   cr_q;
	logic signed [Z_W-1:0]   ci_q;
	logic signed [Z_W-1:0]   zr_q;
	logic signed [Z_W-1:0]   zi_q;
	logic [ITER_W-1:0]       n_q;
	logic                    esc_q;
	logic signed [2*Z_W-1:0] prr_q;
	logic signed [2*Z_W-1:0] pii_q;
	logic signed [2*Z_W-1:0] pri_q;
	logic                    out_valid_q;

	logic signed [MAG_W-1:0] rr;
	logic signed [MAG_W-1:0] ii;
	logic signed [MAG_W-1:0] ri2;
	logic signed [MAG_W-1:0] mag;
	logic signed [MAG_W-1:0] nr_wide;
	logic signed [MAG_W-1:0] ni_wide;
	logic                    at_limit;
	logic                    hit;
	logic                    step;
	logic                    finish;
	logic                    emit;

	assign rr  = MAG_W'(prr_q >>> FRAC_BITS);
	assign ii  = MAG_W'(pii_q >>> FRAC_BITS);
	assign ri2 = MAG_W'(pri_q >>> (FRAC_BITS - 1));
	assign mag = rr + ii;
	assign nr_wide = rr - ii + MAG_W'(cr_q);
	assign ni_wide = ri2 + MAG_W'(ci_q);

	assign at_limit = n_q >= max_iter;
	assign hit      = $unsigned(mag) >= MAG_FOUR;

	always_comb begin
		state_d = state_q;
		job_pop = 1'b0;
		step    = 1'b0;
		finish  = 1'b0;
		emit    = 1'b0;
		case (state_q)
			ENG_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = ENG_MUL;
				end
			end
			ENG_MUL: begin
				state_d = ENG_CHK;
			end
			ENG_CHK: begin
				if (at_limit || hit) begin
					finish  = 1'b1;
					state_d = ENG_OUT;
				end else begin
					step    = 1'b1;
					state_d = ENG_MUL;
				end
			end
			ENG_OUT: begin
				if (!out_valid_q || out_ready) begin
					emit    = 1'b1;
					state_d = ENG_IDLE;
				end
			end
			default: begin
				state_d = ENG_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ENG_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prr_q <= zr_q * zr_q;
		pii_q <= zi_q * zi_q;
		pri_q <= zr_q * zi_q;
		if (job_pop) begin
			x_q  <= job.x;
			y_q  <= job.y;
			cr_q <= job.cr;
			ci_q <= job.ci;
			zr_q <= '0;
			zi_q <= '0;
			n_q  <= '0;
		end
		if (step) begin
			zr_q <= sat32(SAT_W'(nr_wide));
			zi_q <= sat32(SAT_W'(ni_wide));
			n_q  <= n_q + 1'b1;
		end
		if (finish) begin
			// the limit check wins over a late escape
			esc_q <= !at_limit;
		end
		if (emit) begin
			out_x      <= x_q;
			out_y      <= y_q;
			iterations <= n_q;
			escaped    <= esc_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/mandelbrot_escape_time_core.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_core: per-pixel escape-time evaluator
// Maps a pixel to c in Q4.28, iterates z = z*z + c and reports the count.
// ----------------------------------------------------------------------------
// One result per pixel, in input order. Each update of z passes first
// through the three registered 32x32 multipliers and then through the
// magnitude check and z update, and the engine works on one pixel at a
// time. Coordinate mapping runs ahead of the engine through a two-entry
// queue, and a finished result waits in the output register while the
// next pixel starts. Configuration registers are written through
// cfg_we/cfg_index/cfg_data and must only change while no pixel is in
// flight.
module mandelbrot_escape_time_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [mbe_pkg::COORD_BITS-1:0]       pixel_x,
	input  logic [mbe_pkg::COORD_BITS-1:0]       pixel_y,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [mbe_pkg::COORD_BITS-1:0]       out_x,
	output logic [mbe_pkg::COORD_BITS-1:0]       out_y,
	output logic [mbe_pkg::ITER_W-1:0]           iterations,
	output logic                                 escaped,
	input  logic                                 cfg_we,
	input  logic [mbe_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mbe_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import mbe_pkg::*;

	logic [ITER_W-1:0]          max_iter_q;
	logic signed [ORIGIN_W-1:0] re_origin_q;
	logic signed [ORIGIN_W-1:0] im_origin_q;
	logic [STEP_W-1:0]          re_step_q;
	logic [STEP_W-1:0]          im_step_q;

	logic     push;
	logic     q_not_full;
	logic     q_not_empty;
	logic     pop;
	mbe_job_t wr_job;
	mbe_job_t rd_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q  <= MAX_ITER_RST;
			re_origin_q <= RE_ORIGIN_RST;
			im_origin_q <= IM_ORIGIN_RST;
			re_step_q   <= RE_STEP_RST;
			im_step_q   <= IM_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_ITER:  max_iter_q  <= cfg_data[ITER_W-1:0];
				REG_RE_ORIGIN: re_origin_q <= cfg_data[ORIGIN_W-1:0];
				REG_IM_ORIGIN: im_origin_q <= cfg_data[ORIGIN_W-1:0];
				REG_RE_STEP:   re_step_q   <= cfg_data[STEP_W-1:0];
				REG_IM_STEP:   im_step_q   <= cfg_data[STEP_W-1:0];
				default:       max_iter_q  <= max_iter_q;
			endcase
		end
	end

	mbe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.re_origin (re_origin_q),
		.im_origin (im_origin_q),
		.re_step   (re_step_q),
		.im_step   (im_step_q),
		.job_push  (push),
		.job       (wr_job),
		.job_ready (q_not_full)
	);

	mbe_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_job    (wr_job),
		.not_full  (q_not_full),
		.pop       (pop),
		.rd_job    (rd_job),
		.not_empty (q_not_empty)
	);

	mbe_iter u_iter (
		.clk        (clk),
		.arst_n     (arst_n),
		.max_iter   (max_iter_q),
		.job_valid  (q_not_empty),
		.job        (rd_job),
		.job_pop    (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_x      (out_x),
		.out_y      (out_y),
		.iterations (iterations),
		.escaped    (escaped)
	);

endmodule

// ----- rtl/mbe_checker.sv -----
// ----------------------------------------------------------------------------
// mbe_checker: port-level checks for the escape-time core
// Tracks the iteration limit and the number of pixels in flight from the
// ports and checks results against them.
// ----------------------------------------------------------------------------
module mbe_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [mbe_pkg::COORD_BITS-1:0]     out_x,
	input  logic [mbe_pkg::COORD_BITS-1:0]     out_y,
	input  logic [mbe_pkg::ITER_W-1:0]         iterations,
	input  logic                               escaped,
	input  logic                               cfg_we,
	input  logic [mbe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mbe_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import mbe_pkg::*;

	logic [ITER_W-1:0] lim_q;
	logic [PEND_W-1:0] pend_q;
	logic              in_fire;
	logic              out_fire;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q  <= MAX_ITER_RST;
			pend_q <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_MAX_ITER) begin
				lim_q <= cfg_data[ITER_W-1:0];
			end
			case ({in_fire, out_fire})
				2'b10:   pend_q <= pend_q + 1'b1;
				2'b01:   pend_q <= pend_q - 1'b1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({out_x, out_y, iterations, escaped}))
		else $error("stalled result changed or dropped");

	// z starts at zero, so no escape is possible before the first update
	a_no_early_escape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && iterations == '0 |-> !escaped)
		else $error("escape reported with zero updates");

	a_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> iterations <= lim_q)
		else $error("iteration count above limit");

	a_escape_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && escaped |-> iterations < lim_q)
		else $error("escape reported at the limit");

	a_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PEND_W'(OUTSTANDING_MAX) && (!out_valid || pend_q != '0))
		else $error("transaction count out of range");

endmodule

bind mandelbrot_escape_time_core mbe_checker u_mbe_checker (.*);

// ----- tb/tb_mandelbrot_escape_time_core.sv -----
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time_core: self-checking bench for the escape-time core
// Drives pixel transactions under several register views and idle patterns,
// predicts each pixel's count and escape flag in fixed point, and checks
// every returned transaction in order against the predicted one.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time_core;

	import mbe_pkg::*;

	localparam int      SETTLE_CYCLES = 20;
	localparam int      HOLD_CYCLES   = 200;
	localparam longint  ESCAPE_BOUND  = longint'(4) <<< FRAC_BITS;
	localparam longint  Q_MAX         = 64'sd2147483647;
	localparam longint  Q_MIN         = -64'sd2147483648;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct {
		coord_t              x;
		coord_t              y;
		logic [ITER_W-1:0]   count;
		logic                esc;
	} pixel_result_t;

	class escape_scoreboard;
		logic [ITER_W-1:0]   max_iter;
		int                  re_origin;
		int                  im_origin;
		logic [STEP_W-1:0]   re_step;
		logic [STEP_W-1:0]   im_step;
		pixel_result_t       expected_q[$];
		int                  errors;

		function new();
			max_iter  = MAX_ITER_RST;
			re_origin = RE_ORIGIN_RST;
			im_origin = IM_ORIGIN_RST;
			re_step   = RE_STEP_RST;
			im_step   = IM_STEP_RST;
			errors    = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_MAX_ITER:  max_iter  = data[ITER_W-1:0];
				REG_RE_ORIGIN: re_origin = data;
				REG_IM_ORIGIN: im_origin = data;
				REG_RE_STEP:   re_step   = data[STEP_W-1:0];
				REG_IM_STEP:   im_step   = data[STEP_W-1:0];
				default: ;
			endcase
		endfunction

		function longint clamp32(longint v);
			if (v > Q_MAX) return Q_MAX;
			if (v < Q_MIN) return Q_MIN;
			return v;
		endfunction

		function pixel_result_t escape_time(coord_t x, coord_t y);
			longint        px, py, step_r, step_i, cr, ci, zr, zi, rr, ii, twice_ri;
			int unsigned   n;
			bit            out_flag;
			pixel_result_t r;
			px = longint'(x);
			py = longint'(y);
			step_r = longint'(re_step);
			step_i = longint'(im_step);
			cr = clamp32(longint'(re_origin) + px * step_r);
			ci = clamp32(longint'(im_origin) + py * step_i);
			zr = 0;
			zi = 0;
			n = 0;
			out_flag = 0;
			while (n < max_iter && !out_flag) begin
				rr = (zr * zr) >>> FRAC_BITS;
				ii = (zi * zi) >>> FRAC_BITS;
				if (rr + ii >= ESCAPE_BOUND) begin
					out_flag = 1;
				end else begin
					twice_ri = (zr * zi) >>> (FRAC_BITS - 1);
					zr = clamp32(rr - ii + cr);
					zi = clamp32(twice_ri + ci);
					n++;
				end
			end
			r.x = x;
			r.y = y;
			r.count = n[ITER_W-1:0];
			r.esc = out_flag;
			return r;
		endfunction

		function void note_pixel(coord_t x, coord_t y);
			expected_q.push_back(escape_time(x, y));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(string msg);
			$display("MISMATCH %s", msg);
			errors++;
		endtask

		task check_result(coord_t x, coord_t y, logic [ITER_W-1:0] count, logic esc);
			pixel_result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected transaction x=%0d y=%0d n=%0d esc=%0b",
					x, y, count, esc));
				return;
			end
			want = expected_q.pop_front();
			if (x !== want.x || y !== want.y || count !== want.count || esc !== want.esc) begin
				report($sformatf("got x=%0d y=%0d n=%0d esc=%0b, want x=%0d y=%0d n=%0d esc=%0b",
					x, y, count, esc, want.x, want.y, want.count, want.esc));
			end
		endtask
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	coord_t                  pixel_x;
	coord_t                  pixel_y;
	logic                    out_valid;
	logic                    out_ready;
	coord_t                  out_x;
	coord_t                  out_y;
	logic [ITER_W-1:0]       iterations;
	logic                    escaped;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	escape_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int rx_hold_req;

	mandelbrot_escape_time_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_x      (out_x),
		.out_y      (out_y),
		.iterations (iterations),
		.escaped    (escaped),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(64'd50_000_000);
		$display("simulation failed");
		$finish;
	end

	// result side: check, then pick out_ready for the next cycle
	initial begin
		int rx_hold_seen;
		int rx_hold_left;
		rx_hold_seen = 0;
		rx_hold_left = 0;
		out_ready = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_result(out_x, out_y, iterations, escaped);
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				out_ready <= 0;
			end else if (rx_hold_req != rx_hold_seen) begin
				rx_hold_seen = rx_hold_req;
				rx_hold_left = HOLD_CYCLES;
				out_ready <= 0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_pixel(input coord_t x, input coord_t y);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		pixel_x <= x;
		pixel_y <= y;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_pixel(x, y);
	endtask

	// drop valid and let every outstanding pixel come back
	task automatic wait_idle();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic set_view(input logic [31:0] limit_word, input logic [31:0] re_o,
		input logic [31:0] im_o, input logic [31:0] re_s, input logic [31:0] im_s);
		write_reg(REG_MAX_ITER, limit_word);
		write_reg(REG_RE_ORIGIN, re_o);
		write_reg(REG_IM_ORIGIN, im_o);
		write_reg(REG_RE_STEP, re_s);
		write_reg(REG_IM_STEP, im_s);
		cfg_we <= 0;
	endtask

	task automatic random_block(input int items, input bit quick);
		logic [31:0] limit_word, re_o, im_o, re_s, im_s;
		limit_word = $urandom() & 32'hFFFF_0000;
		if (quick)
			limit_word |= $urandom_range(1, 8);
		else if ($urandom_range(9) == 0)
			limit_word |= $urandom_range(0, 3);
		else
			limit_word |= $urandom_range(1, 200);
		if ($urandom_range(3) == 0) begin
			re_o = $urandom();
			im_o = $urandom();
			re_s = $urandom();
			im_s = $urandom();
		end else begin
			// window origins around the set: re origin in [-2, 0], im origin in [-1.5, 0]
			re_o = -$urandom_range(0, 32'd1 << 29);
			im_o = -$urandom_range(0, 32'd3 << 27);
			re_s = $urandom_range(0, 200000) | ($urandom() & 32'h8000_0000);
			im_s = $urandom_range(0, 200000) | ($urandom() & 32'h8000_0000);
		end
		set_view(limit_word, re_o, im_o, re_s, im_s);
		// stall the result side so the core backs up into its input
		if (quick)
			rx_hold_req++;
		repeat (items)
			send_pixel(coord_t'($urandom_range(4095)), coord_t'($urandom_range(4095)));
		wait_idle();
	endtask

	initial begin
		in_valid = 0;
		pixel_x = '0;
		pixel_y = '0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 0;
		rx_hold_req = 0;
		send_idle_pct = 7;
		recv_idle_pct = 87;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset view: corners and a point inside the set
		send_pixel(0, 0);
		send_pixel(4095, 4095);
		send_pixel(960, 540);
		send_pixel(0, 4095);
		send_pixel(4095, 0);
		wait_idle();

		// zero limit (upper data bits ignored), extreme origins and steps
		set_view(32'hFFFF_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
		send_pixel(0, 0);
		send_pixel(4095, 4095);
		wait_idle();

		// single update: saturated coordinates count as inside at the limit
		write_reg(REG_MAX_ITER, 32'd1);
		cfg_we <= 0;
		send_pixel(4095, 0);
		send_pixel(0, 4095);
		wait_idle();

		// unit steps: magnitude exactly four, escape at the limit, saturation
		set_view(32'd2, 32'd0, 32'd0, 32'd1 << FRAC_BITS, 32'd1 << FRAC_BITS);
		send_pixel(2, 0);
		send_pixel(1, 1);
		send_pixel(0, 0);
		send_pixel(4095, 4095);
		wait_idle();

		// largest limit
		set_view(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1 << 20, 32'd1 << 20);
		send_pixel(0, 0);
		send_pixel(1024, 1024);
		send_pixel(100, 30);
		wait_idle();

		repeat (4) random_block(10, 0);
		send_idle_pct = 87;
		recv_idle_pct = 7;
		repeat (4) random_block(10, 0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_block(10, 1);
		repeat (3) random_block(10, 0);

		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
